// ----- src/dbf_pkg.sv -----
// Shared types and constants of the display brightness fader.
package dbf_pkg;

    // Width of a contrast level and of a step count.
    localparam int LVL_W = 8;

    // Opcodes of an input item.
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_DIM     = 3'd1;
    localparam logic [2:0] OP_WAKE    = 3'd2;
    localparam logic [2:0] OP_INSTANT = 3'd3;
    localparam logic [2:0] OP_SET     = 3'd4;
    localparam logic [2:0] OP_AUTO    = 3'd5;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_DIM_LEVEL     = 3'd0;
    localparam logic [2:0] REG_DIM_STEPS     = 3'd1;
    localparam logic [2:0] REG_WAKE_STEPS    = 3'd2;
    localparam logic [2:0] REG_DIM_INTERVAL  = 3'd3;
    localparam logic [2:0] REG_WAKE_INTERVAL = 3'd4;
    localparam logic [2:0] REG_AUTO_DELAY    = 3'd5;
    localparam logic [2:0] REG_INIT_LEVEL    = 3'd6;

    // Register reset values.
    localparam logic [7:0]  RST_DIM_LEVEL     = 8'd0;
    localparam logic [7:0]  RST_DIM_STEPS     = 8'd8;
    localparam logic [7:0]  RST_WAKE_STEPS    = 8'd3;
    localparam logic [15:0] RST_DIM_INTERVAL  = 16'd60;
    localparam logic [15:0] RST_WAKE_INTERVAL = 16'd40;
    localparam logic [31:0] RST_AUTO_DELAY    = 32'd0;
    localparam logic [7:0]  RST_INIT_LEVEL    = 8'd207;

    // Fade mode as reported on the output.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_DIM  = 2'd1,
        MODE_WAKE = 2'd2
    } t_mode;

    // Sequencer states of the fade engine.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_STEP1,
        S_STEP2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] now_ms;
        logic [7:0]  level_value;
        logic [31:0] last_activity_ms;
    } t_in_item;

    typedef struct packed {
        logic       write_valid;
        logic [7:0] contrast_value;
        logic       dimmed_flag;
        logic [1:0] fade_mode;
        logic       last_of_run;
    } t_out_item;

    // Configuration seen by the fade engine.
    typedef struct packed {
        logic [7:0]  dim_level;
        logic [7:0]  dim_step_count;
        logic [7:0]  wake_step_count;
        logic [15:0] dim_step_interval_ms;
        logic [15:0] wake_step_interval_ms;
        logic [31:0] auto_dim_delay_ms;
    } t_cfg;

    // Divider start request and response.
    typedef struct packed {
        logic             start;
        logic [LVL_W-1:0] dividend;
        logic [LVL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [LVL_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- src/dbf_div.sv -----
// Restoring serial divider for the fade step size, one quotient bit per cycle.
module dbf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dbf_pkg::t_div_req i_req,
    output dbf_pkg::t_div_rsp o_rsp
);
    import dbf_pkg::*;

    localparam int CNT_W = $clog2(LVL_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [LVL_W-1:0] r_rem;
    logic [LVL_W-1:0] r_quo;
    logic [LVL_W-1:0] r_div;

    logic [LVL_W:0]   shifted;
    logic             fits;
    logic [LVL_W-1:0] n_rem;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        shifted = {r_rem, r_quo[LVL_W-1]};
        fits    = shifted >= {1'b0, r_div};
        if (fits) begin
            n_rem = LVL_W'(shifted - {1'b0, r_div});
        end else begin
            n_rem = shifted[LVL_W-1:0];
        end
    end

    // Control: busy while the LVL_W quotient bits are formed, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(LVL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[LVL_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- src/dbf_core.sv -----
// Fade engine: sequencer, fade state and result delivery.
module dbf_core #(
    parameter int TIME_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dbf_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dbf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dbf_pkg::t_out_item o_out_data
);
    import dbf_pkg::*;

    localparam int EXT_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    t_state                 r_state, n_state;
    t_mode                  r_mode, n_mode;
    logic                   r_dimmed, n_dimmed;
    logic [LVL_W-1:0]       r_normal, n_normal;
    logic [LVL_W-1:0]       r_cur, n_cur;
    logic [LVL_W-1:0]       r_sent, n_sent;
    logic [LVL_W-1:0]       r_steps, n_steps;
    logic [TIME_BITS-1:0]   r_time, n_time;
    logic [2:0]             r_op, n_op;
    logic [TIME_BITS-1:0]   r_now, n_now;
    logic [TIME_BITS-1:0]   r_last, n_last;
    logic [LVL_W-1:0]       r_lvl, n_lvl;
    logic [1:0]             r_wcnt, n_wcnt;
    logic [LVL_W-1:0]       r_wv0, n_wv0;
    logic [LVL_W-1:0]       r_wv1, n_wv1;
    logic                   r_fin, n_fin;
    logic                   r_idx, n_idx;

    logic [EXT_W-1:0]       now_ext;
    logic [EXT_W-1:0]       last_ext;
    logic [TIME_BITS-1:0]   step_elapsed;
    logic [TIME_BITS-1:0]   idle_elapsed;
    logic [15:0]            interval;
    logic                   fading;
    logic                   tick_due;
    logic                   auto_due;
    logic                   in_accept;
    logic                   out_accept;
    logic                   out_last;
    logic [LVL_W-1:0]       divisor;
    logic [LVL_W-1:0]       step;
    logic [LVL_W:0]         dim_floor;
    logic [LVL_W:0]         wake_sum;
    logic [LVL_W-1:0]       lvl_dim;
    logic [LVL_W-1:0]       lvl_wake;
    logic [LVL_W-1:0]       step_lvl;
    logic [LVL_W-1:0]       bound;
    logic                   out_of_steps;
    t_div_req               div_req;
    t_div_rsp               div_rsp;

    // Shared divider for the step size.
    dbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Timestamps are taken modulo 2^TIME_BITS.
    assign now_ext  = EXT_W'(i_in_data.now_ms);
    assign last_ext = EXT_W'(i_in_data.last_activity_ms);

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = o_out_valid && !i_out_stall;
    assign out_last   = !(r_wcnt == 2'd2 && !r_idx);

    // Timing checks for a fade step and for auto dim.
    always_comb begin
        fading       = (r_mode == MODE_DIM) || (r_mode == MODE_WAKE);
        interval     = (r_mode == MODE_DIM) ? i_cfg.dim_step_interval_ms
                                            : i_cfg.wake_step_interval_ms;
        step_elapsed = r_now - r_time;
        idle_elapsed = r_now - r_last;
        tick_due     = fading && (EXT_W'(step_elapsed) >= EXT_W'(interval));
        auto_due     = (i_cfg.auto_dim_delay_ms != '0)
                    && (EXT_W'(idle_elapsed) >= EXT_W'(i_cfg.auto_dim_delay_ms))
                    && !r_dimmed && (r_mode == MODE_IDLE);
    end

    // Step size and the level after one step.
    always_comb begin
        divisor = (r_mode == MODE_DIM) ? i_cfg.dim_step_count : i_cfg.wake_step_count;
        if (divisor == '0) begin
            divisor = LVL_W'(1);
        end
        div_req.start    = (r_state == S_EXEC) && (r_op == OP_TICK) && tick_due;
        div_req.dividend = r_normal - i_cfg.dim_level;
        div_req.divisor  = divisor;

        if ((r_normal > i_cfg.dim_level) && (div_rsp.quotient > LVL_W'(1))) begin
            step = div_rsp.quotient;
        end else begin
            step = LVL_W'(1);
        end
        dim_floor = {1'b0, step} + {1'b0, i_cfg.dim_level};
        lvl_dim   = ({1'b0, r_cur} > dim_floor) ? (r_cur - step) : i_cfg.dim_level;
        wake_sum  = {1'b0, r_cur} + {1'b0, step};
        lvl_wake  = (wake_sum < {1'b0, r_normal}) ? wake_sum[LVL_W-1:0] : r_normal;
        step_lvl  = (r_mode == MODE_DIM) ? lvl_dim : lvl_wake;
        bound     = (r_mode == MODE_DIM) ? i_cfg.dim_level : r_normal;
        out_of_steps = r_steps <= LVL_W'(1);
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = div_req.start ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_STEP1;
                end
            end
            S_STEP1: begin
                n_state = S_STEP2;
            end
            S_STEP2: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_accept && out_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Fade state, latched request and pending contrast writes.
    always_comb begin
        n_mode   = r_mode;
        n_dimmed = r_dimmed;
        n_normal = r_normal;
        n_cur    = r_cur;
        n_sent   = r_sent;
        n_steps  = r_steps;
        n_time   = r_time;
        n_op     = r_op;
        n_now    = r_now;
        n_last   = r_last;
        n_lvl    = r_lvl;
        n_wcnt   = r_wcnt;
        n_wv0    = r_wv0;
        n_wv1    = r_wv1;
        n_fin    = r_fin;
        n_idx    = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op   = i_in_data.opcode;
                    n_now  = now_ext[TIME_BITS-1:0];
                    n_last = last_ext[TIME_BITS-1:0];
                    n_lvl  = i_in_data.level_value;
                    n_wcnt = 2'd0;
                    n_idx  = 1'b0;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_TICK: begin
                        if (tick_due) begin
                            n_time = r_now;
                        end
                    end
                    OP_DIM: begin
                        if (!(r_dimmed || r_mode == MODE_DIM)) begin
                            n_mode  = MODE_DIM;
                            n_steps = i_cfg.dim_step_count;
                            n_time  = r_now;
                        end
                    end
                    OP_WAKE: begin
                        if (r_dimmed || r_mode == MODE_DIM) begin
                            n_mode  = MODE_WAKE;
                            n_steps = i_cfg.wake_step_count;
                            n_time  = r_now;
                        end
                    end
                    OP_INSTANT: begin
                        n_mode   = MODE_IDLE;
                        n_cur    = r_normal;
                        n_dimmed = 1'b0;
                        if (r_normal != r_sent) begin
                            n_sent = r_normal;
                            n_wv0  = r_normal;
                            n_wcnt = 2'd1;
                        end
                    end
                    OP_SET: begin
                        n_normal = r_lvl;
                        if (!r_dimmed) begin
                            n_cur = r_lvl;
                            if (r_lvl != r_sent) begin
                                n_sent = r_lvl;
                                n_wv0  = r_lvl;
                                n_wcnt = 2'd1;
                            end
                        end else begin
                            n_cur = i_cfg.dim_level;
                        end
                    end
                    OP_AUTO: begin
                        if (auto_due) begin
                            n_mode  = MODE_DIM;
                            n_steps = i_cfg.dim_step_count;
                            n_time  = r_now;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
            end
            S_STEP1: begin
                // One step toward the bound; the fade ends at the bound or out of steps.
                n_cur   = step_lvl;
                n_steps = out_of_steps ? '0 : r_steps - 1'b1;
                n_fin   = out_of_steps || (step_lvl == bound);
                if (step_lvl != r_sent) begin
                    n_sent = step_lvl;
                    n_wv0  = step_lvl;
                    n_wcnt = 2'd1;
                end
            end
            S_STEP2: begin
                if (r_fin) begin
                    n_cur    = bound;
                    n_dimmed = (r_mode == MODE_DIM);
                    n_mode   = MODE_IDLE;
                    n_steps  = '0;
                    if (bound != r_sent) begin
                        n_sent = bound;
                        n_wcnt = r_wcnt + 2'd1;
                        if (r_wcnt == 2'd0) begin
                            n_wv0 = bound;
                        end else begin
                            n_wv1 = bound;
                        end
                    end
                end
            end
            S_OUT: begin
                if (out_accept && !out_last) begin
                    n_idx = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and fade state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_IDLE;
            r_dimmed <= 1'b0;
            r_normal <= RST_INIT_LEVEL;
            r_cur    <= RST_INIT_LEVEL;
            r_sent   <= RST_INIT_LEVEL;
            r_steps  <= '0;
            r_time   <= '0;
            r_wcnt   <= 2'd0;
            r_idx    <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_dimmed <= n_dimmed;
            r_normal <= n_normal;
            r_cur    <= n_cur;
            r_sent   <= n_sent;
            r_steps  <= n_steps;
            r_time   <= n_time;
            r_wcnt   <= n_wcnt;
            r_idx    <= n_idx;
            r_fin    <= n_fin;
        end
    end

    // Latched request and write values.
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_now  <= n_now;
        r_last <= n_last;
        r_lvl  <= n_lvl;
        r_wv0  <= n_wv0;
        r_wv1  <= n_wv1;
    end

    // Result delivery from the registered write list; no request is taken in reset.
    always_comb begin
        o_in_stall                = (r_state != S_IDLE) || !i_rst_n;
        o_out_valid               = (r_state == S_OUT);
        o_out_data.write_valid    = (r_wcnt != 2'd0);
        o_out_data.contrast_value = (r_wcnt == 2'd0) ? '0 : (r_idx ? r_wv1 : r_wv0);
        o_out_data.dimmed_flag    = r_dimmed;
        o_out_data.fade_mode      = 2'(r_mode);
        o_out_data.last_of_run    = out_last;
    end

endmodule

// ----- src/display_brightness_fader_unit.sv -----
// Top level of the display brightness fader: register port and fade engine.
//
// Usage: requests enter on i_in_valid / o_in_stall / i_in_data, one timestamped
// event each (tick, dim, smooth wake, instant wake, set level, auto-dim check).
// Results leave on o_out_valid / i_out_stall / o_out_data: one or two contrast
// writes per request, or a single status result when nothing is sent; the
// last_of_run bit marks the final result of a request.
// A tick that takes a fade step goes from acceptance through S_EXEC, S_DIV,
// where the serial divider forms the step size, S_STEP1 and S_STEP2 to S_OUT;
// every other request goes from S_EXEC straight to S_OUT.
// Each further result is shown in the cycle after the previous one is taken.
// One request is handled at a time: o_in_stall stays high from acceptance
// until the last result is taken, so a new request is accepted the cycle after.
// While i_out_stall is high the current result holds on o_out_data.
// Reset (i_rst_n low at a clock edge) restores the register defaults, an idle
// undimmed fade state at the default level, and sends no write.
// Registers sit at byte address 4*index on the APB-style port; pready is high.
module display_brightness_fader_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dbf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dbf_pkg::t_out_item o_out_data
);
    import dbf_pkg::*;

    logic [7:0]  r_dim_level;
    logic [7:0]  r_dim_steps;
    logic [7:0]  r_wake_steps;
    logic [15:0] r_dim_interval;
    logic [15:0] r_wake_interval;
    logic [31:0] r_auto_delay;
    logic [7:0]  r_init_level;

    logic        cfg_write;
    logic [2:0]  reg_index;
    t_cfg        cfg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:2];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_level     <= RST_DIM_LEVEL;
            r_dim_steps     <= RST_DIM_STEPS;
            r_wake_steps    <= RST_WAKE_STEPS;
            r_dim_interval  <= RST_DIM_INTERVAL;
            r_wake_interval <= RST_WAKE_INTERVAL;
            r_auto_delay    <= RST_AUTO_DELAY;
            r_init_level    <= RST_INIT_LEVEL;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_DIM_LEVEL:     r_dim_level     <= pwdata[7:0];
                REG_DIM_STEPS:     r_dim_steps     <= pwdata[7:0];
                REG_WAKE_STEPS:    r_wake_steps    <= pwdata[7:0];
                REG_DIM_INTERVAL:  r_dim_interval  <= pwdata[15:0];
                REG_WAKE_INTERVAL: r_wake_interval <= pwdata[15:0];
                REG_AUTO_DELAY:    r_auto_delay    <= pwdata;
                REG_INIT_LEVEL:    r_init_level    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_index)
            REG_DIM_LEVEL:     prdata = 32'(r_dim_level);
            REG_DIM_STEPS:     prdata = 32'(r_dim_steps);
            REG_WAKE_STEPS:    prdata = 32'(r_wake_steps);
            REG_DIM_INTERVAL:  prdata = 32'(r_dim_interval);
            REG_WAKE_INTERVAL: prdata = 32'(r_wake_interval);
            REG_AUTO_DELAY:    prdata = r_auto_delay;
            REG_INIT_LEVEL:    prdata = 32'(r_init_level);
            default:           prdata = '0;
        endcase
    end

    // Settings used by the fade engine.
    always_comb begin
        cfg.dim_level             = r_dim_level;
        cfg.dim_step_count        = r_dim_steps;
        cfg.wake_step_count       = r_wake_steps;
        cfg.dim_step_interval_ms  = r_dim_interval;
        cfg.wake_step_interval_ms = r_wake_interval;
        cfg.auto_dim_delay_ms     = r_auto_delay;
    end

    dbf_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // No new request is taken while a result is pending.
    a_no_accept_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request accepted while a result is pending");

    // An accepted request blocks the input on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not blocked after acceptance");

    // A status result is the only result of its request and carries level zero.
    a_status_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.write_valid) |->
            (o_out_data.last_of_run && o_out_data.contrast_value == 8'd0))
        else $error("malformed status result");
`endif

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench of the display brightness fader with its own fade predictor.
`timescale 1ns / 100ps

module tb;
    import dbf_pkg::*;

    localparam int          HALF_PERIOD    = 2;
    localparam int          RESET_CYCLES   = 12;
    localparam int          RANDOM_PHASES  = 10;
    localparam int          PHASE_EVENTS   = 155;
    localparam int          HOLD_PHASE     = 4;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int          SETTLE_CYCLES  = 32;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    // Clock, reset and block ports.
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_data  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;

    // Configuration copy held by the predictor.
    logic [7:0]  cfg_dim_level  = RST_DIM_LEVEL;
    logic [7:0]  cfg_dim_steps  = RST_DIM_STEPS;
    logic [7:0]  cfg_wake_steps = RST_WAKE_STEPS;
    logic [15:0] cfg_dim_ivl    = RST_DIM_INTERVAL;
    logic [15:0] cfg_wake_ivl   = RST_WAKE_INTERVAL;
    logic [31:0] cfg_auto_delay = RST_AUTO_DELAY;

    // Fade state held by the predictor.
    t_mode       st_mode      = MODE_IDLE;
    logic        st_dimmed    = 1'b0;
    logic [7:0]  st_normal    = RST_INIT_LEVEL;
    logic [7:0]  st_current   = RST_INIT_LEVEL;
    logic [7:0]  st_sent      = RST_INIT_LEVEL;
    logic [7:0]  st_steps     = '0;
    logic [31:0] st_step_time = '0;
    logic [7:0]  panel_writes[$];

    // Request and result bookkeeping.
    t_in_item    pending_events[$];
    t_out_item   due_results[$];
    int unsigned queued_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_req_cnt = 0;
    int unsigned hold_served  = 0;
    bit          quiet_phase  = 1'b0;
    logic [31:0] cur_time     = '0;

    display_brightness_fader_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Wait drawn by either side before its next request or result.
    function automatic int unsigned draw_wait();
        return quiet_phase ? 0 : $urandom_range(0, 15);
    endfunction

    // A contrast write reaches the panel only when it differs from the last one.
    task automatic send_contrast(input logic [7:0] lvl);
        if (lvl != st_sent) begin
            st_sent = lvl;
            if (panel_writes.size() < 2) panel_writes.push_back(lvl);
        end
    endtask

    task automatic begin_dim(input logic [31:0] now);
        if (st_dimmed || st_mode == MODE_DIM) return;
        st_mode      = MODE_DIM;
        st_steps     = cfg_dim_steps;
        st_step_time = now;
    endtask

    // Advance the fade state by one request and queue the results it causes.
    task automatic predict_contrast(input t_in_item ev);
        logic [31:0] elapsed;
        logic [15:0] ivl;
        int          divisor, diff, step, lvl, dim_lvl, norm_lvl;
        bit          last_step;
        t_out_item   res;

        panel_writes.delete();
        dim_lvl  = int'(cfg_dim_level);
        norm_lvl = int'(st_normal);
        case (ev.opcode)
            OP_TICK: begin
                if (st_mode == MODE_DIM || st_mode == MODE_WAKE) begin
                    ivl     = (st_mode == MODE_DIM) ? cfg_dim_ivl : cfg_wake_ivl;
                    elapsed = ev.now_ms - st_step_time;
                    if (elapsed >= 32'(ivl)) begin
                        st_step_time = ev.now_ms;
                        divisor = int'((st_mode == MODE_DIM) ? cfg_dim_steps
                                                             : cfg_wake_steps);
                        if (divisor == 0) divisor = 1;
                        diff = norm_lvl - dim_lvl;
                        step = 1;
                        if (diff > 0 && diff / divisor > 1) step = diff / divisor;
                        last_step = (st_steps <= 8'd1);
                        st_steps  = last_step ? 8'd0 : st_steps - 8'd1;
                        lvl = int'(st_current);
                        if (st_mode == MODE_DIM) begin
                            lvl = (lvl > step + dim_lvl) ? lvl - step : dim_lvl;
                            st_current = lvl[7:0];
                            send_contrast(lvl[7:0]);
                            if (last_step || lvl <= dim_lvl) begin
                                st_current = cfg_dim_level;
                                send_contrast(cfg_dim_level);
                                st_dimmed = 1'b1;
                                st_mode   = MODE_IDLE;
                                st_steps  = '0;
                            end
                        end else begin
                            lvl = (lvl + step < norm_lvl) ? lvl + step : norm_lvl;
                            st_current = lvl[7:0];
                            send_contrast(lvl[7:0]);
                            if (last_step || lvl >= norm_lvl) begin
                                st_current = st_normal;
                                send_contrast(st_normal);
                                st_dimmed = 1'b0;
                                st_mode   = MODE_IDLE;
                                st_steps  = '0;
                            end
                        end
                    end
                end
            end
            OP_DIM: begin_dim(ev.now_ms);
            OP_WAKE: begin
                if (st_dimmed || st_mode == MODE_DIM) begin
                    st_mode      = MODE_WAKE;
                    st_steps     = cfg_wake_steps;
                    st_step_time = ev.now_ms;
                end
            end
            OP_INSTANT: begin
                st_mode    = MODE_IDLE;
                st_current = st_normal;
                send_contrast(st_normal);
                st_dimmed  = 1'b0;
            end
            OP_SET: begin
                st_normal = ev.level_value;
                if (!st_dimmed) begin
                    st_current = ev.level_value;
                    send_contrast(ev.level_value);
                end else begin
                    st_current = cfg_dim_level;
                end
            end
            OP_AUTO: begin
                elapsed = ev.now_ms - ev.last_activity_ms;
                if (cfg_auto_delay != 0 && elapsed >= cfg_auto_delay &&
                    !st_dimmed && st_mode == MODE_IDLE)
                    begin_dim(ev.now_ms);
            end
            default: ;
        endcase

        // A request that sends nothing still reports its status once.
        res.dimmed_flag = st_dimmed;
        res.fade_mode   = st_mode;
        if (panel_writes.size() == 0) begin
            res.write_valid    = 1'b0;
            res.contrast_value = '0;
            res.last_of_run    = 1'b1;
            due_results.push_back(res);
        end else begin
            foreach (panel_writes[k]) begin
                res.write_valid    = 1'b1;
                res.contrast_value = panel_writes[k];
                res.last_of_run    = (k == panel_writes.size() - 1);
                due_results.push_back(res);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // Compare one taken result with the oldest pending expectation.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (due_results.size() == 0) begin
            report_mismatch("unexpected result", 32'(got), '0);
            return;
        end
        want = due_results.pop_front();
        if (got.write_valid !== want.write_valid)
            report_mismatch("write_valid", 32'(got.write_valid), 32'(want.write_valid));
        if (got.contrast_value !== want.contrast_value)
            report_mismatch("contrast_value", 32'(got.contrast_value),
                            32'(want.contrast_value));
        if (got.dimmed_flag !== want.dimmed_flag)
            report_mismatch("dimmed_flag", 32'(got.dimmed_flag), 32'(want.dimmed_flag));
        if (got.fade_mode !== want.fade_mode)
            report_mismatch("fade_mode", 32'(got.fade_mode), 32'(want.fade_mode));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
    endtask

    // Request driver: presents queued events with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_contrast(in_data);
                accepted_cnt++;
            end
            if (in_valid && in_stall) begin
                // The stalled request holds unchanged.
            end else if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_events.size() != 0) begin
                in_data  <= pending_events.pop_front();
                in_valid <= 1'b1;
                gap_left <= draw_wait();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks every taken result and stalls at random.
    always @(posedge i_clk) begin : result_monitor
        int unsigned nxt;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            nxt = stall_left;
            if (out_valid && !out_stall) begin
                check_result(out_data);
                nxt = draw_wait();
            end else if (nxt != 0) begin
                nxt = nxt - 1;
            end
            // A long hold-off lets requests back up behind the output.
            if (hold_req_cnt != hold_served) begin
                nxt = LONG_HOLD;
                hold_served = hold_req_cnt;
            end
            stall_left <= nxt;
            out_stall  <= (nxt != 0);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DIM_LEVEL:     cfg_dim_level  = val[7:0];
            REG_DIM_STEPS:     cfg_dim_steps  = val[7:0];
            REG_WAKE_STEPS:    cfg_wake_steps = val[7:0];
            REG_DIM_INTERVAL:  cfg_dim_ivl    = val[15:0];
            REG_WAKE_INTERVAL: cfg_wake_ivl   = val[15:0];
            REG_AUTO_DELAY:    cfg_auto_delay = val;
            // The initial level register never reaches the fade engine, so it is not modelled.
            default: ;
        endcase
    endtask

    function automatic logic [7:0] draw_steps();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [15:0] draw_interval();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 100));
        endcase
    endfunction

    // Write every register with the setting of the given phase.
    task automatic load_config(input int ph);
        logic [7:0]  dl, ds, ws, il;
        logic [15:0] di, wi;
        logic [31:0] ad;
        case (ph)
            0: begin
                dl = 8'd0; ds = 8'd1; ws = 8'd1; di = 16'd0; wi = 16'd0;
                ad = 32'd1; il = 8'd0;
            end
            1: begin
                dl = 8'hFF; ds = 8'hFF; ws = 8'hFF; di = 16'hFFFF; wi = 16'hFFFF;
                ad = 32'hFFFF_FFFF; il = 8'hFF;
            end
            2: begin
                // Zero step counts fall back to a divisor of one.
                dl = 8'($urandom_range(0, 255)); ds = 8'd0; ws = 8'd0;
                di = 16'($urandom_range(0, 30)); wi = 16'($urandom_range(0, 30));
                ad = $urandom_range(1, 200); il = 8'($urandom_range(0, 255));
            end
            default: begin
                dl = 8'($urandom_range(0, 255));
                ds = draw_steps();
                ws = draw_steps();
                di = draw_interval();
                wi = draw_interval();
                case ($urandom_range(0, 3))
                    0:       ad = 32'd0;
                    1:       ad = 32'hFFFF_FFFF;
                    2:       ad = $urandom;
                    default: ad = $urandom_range(1, 500);
                endcase
                il = 8'($urandom_range(0, 255));
            end
        endcase
        write_reg(REG_DIM_LEVEL,     32'(dl));
        write_reg(REG_DIM_STEPS,     32'(ds));
        write_reg(REG_WAKE_STEPS,    32'(ws));
        write_reg(REG_DIM_INTERVAL,  32'(di));
        write_reg(REG_WAKE_INTERVAL, 32'(wi));
        write_reg(REG_AUTO_DELAY,    ad);
        write_reg(REG_INIT_LEVEL,    32'(il));
        @(negedge i_clk);
    endtask

    task automatic queue_event(input logic [2:0] op, input logic [31:0] now,
                               input logic [7:0] lvl, input logic [31:0] last);
        t_in_item ev;
        ev.opcode           = op;
        ev.now_ms           = now;
        ev.level_value      = lvl;
        ev.last_activity_ms = last;
        pending_events.push_back(ev);
        queued_cnt++;
    endtask

    // A fade start (dim, wake or auto dim) followed by a run of timed ticks.
    task automatic gen_fade_run();
        int unsigned kind, ticks, steps;
        logic [15:0] ivl;
        logic [31:0] last;
        kind = $urandom_range(0, 2);
        cur_time += $urandom_range(0, 50);
        case (kind)
            0: queue_event(OP_DIM, cur_time, 8'($urandom), $urandom);
            1: queue_event(OP_WAKE, cur_time, 8'($urandom), $urandom);
            default: begin
                if ($urandom_range(0, 3) == 0)
                    last = cur_time - $urandom_range(0, cfg_auto_delay);
                else
                    last = cur_time - cfg_auto_delay - $urandom_range(0, 2);
                queue_event(OP_AUTO, cur_time, 8'($urandom), last);
            end
        endcase
        ivl   = (kind == 1) ? cfg_wake_ivl : cfg_dim_ivl;
        steps = 32'((kind == 1) ? cfg_wake_steps : cfg_dim_steps);
        ticks = $urandom_range(1, ((steps > 14) ? 14 : steps) + 2);
        repeat (ticks) begin
            if ($urandom_range(0, 3) != 0)
                cur_time += ivl + $urandom_range(0, 3);
            else
                cur_time += $urandom_range(0, ivl);
            queue_event(OP_TICK, cur_time, 8'($urandom), $urandom);
        end
    endtask

    // Mostly well-formed fades, with level changes and noise mixed in.
    task automatic gen_phase_events(input int unsigned count);
        int unsigned target;
        target = queued_cnt + count;
        cur_time = ($urandom_range(0, 1) != 0) ? $urandom : 32'hFFFF_FF00;
        while (queued_cnt < target) begin
            case ($urandom_range(0, 9))
                7: queue_event(OP_SET, cur_time, 8'($urandom), $urandom);
                8: queue_event(OP_INSTANT, cur_time, 8'($urandom), $urandom);
                9: begin
                    cur_time = $urandom;
                    queue_event(3'($urandom_range(0, 7)), cur_time, 8'($urandom), $urandom);
                end
                default: gen_fade_run();
            endcase
        end
    endtask

    // Let every queued request drain and every expected result arrive.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_events.size() != 0 || in_valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Run sequence: reset, directed requests, then phases of random requests.
    initial begin : run_sequence
        logic [31:0] base;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset defaults.
        base = 32'hFFFF_FFC0;
        queue_event(OP_TICK, 32'd1000, 8'hFF, 32'hFFFF_FFFF);
        queue_event(OP_SET, 32'd1001, 8'hFF, 32'd0);
        queue_event(OP_SET, 32'd1002, 8'hFF, 32'd0);
        queue_event(OP_SET, 32'd1003, 8'h00, 32'd0);
        queue_event(OP_SET, 32'd1004, 8'd207, 32'd0);
        queue_event(OP_AUTO, 32'hFFFF_FFFF, 8'd0, 32'd0);
        // A dim fade whose timestamps wrap through zero.
        queue_event(OP_DIM, base, 8'd0, 32'd0);
        queue_event(OP_TICK, base + 32'd59, 8'd0, 32'd0);
        for (int k = 1; k <= 8; k++)
            queue_event(OP_TICK, base + 32'(60 * k), 8'd0, 32'd0);
        queue_event(OP_DIM, 32'd500, 8'd0, 32'd0);
        queue_event(OP_SET, 32'd510, 8'd100, 32'd0);
        queue_event(OP_WAKE, 32'd600, 8'd0, 32'd0);
        for (int k = 1; k <= 3; k++)
            queue_event(OP_TICK, 32'd600 + 32'(40 * k), 8'd0, 32'd0);
        queue_event(OP_INSTANT, 32'hFFFF_FFFF, 8'd0, 32'd0);
        queue_event(3'd6, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        queue_event(3'd7, 32'd0, 8'd0, 32'd0);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            quiet_phase = (ph % 4 == 1);
            load_config(ph);
            gen_phase_events(PHASE_EVENTS);
            if (ph == HOLD_PHASE) begin
                base = accepted_cnt + 40;
                while (accepted_cnt < base) @(negedge i_clk);
                hold_req_cnt++;
            end
            wait_drained();
        end

        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
src/dbf_pkg.sv
src/dbf_div.sv
src/dbf_core.sv
src/display_brightness_fader_unit.sv
bench/tb.sv
